FILE: src/assert_macros.svh
// Assertion macros for the sorted set table.
// Taken in by the top level; expects signals clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset.
`define SST_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sorted_set_table check failed");

// Antecedent implies consequent in the next cycle.
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_set_table sequence check failed");

`else

`define SST_ASSERT(label, expr)
`define SST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/sst_pkg.sv
// Shared types and constants for the sorted set table.
// No dependencies; used by sst_cell, sorted_set_table and the testbench.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int VAL_W       = 32;
  localparam int DEPTH_DEF   = 64;
  localparam int CAP_W       = 7;
  localparam int CNT_OUT_W   = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic signed [VAL_W-1:0] FILL_VALUE = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                    shift_up;
    logic                    shift_down;
    logic signed [VAL_W-1:0] key;
  } cmd_t;

endpackage

FILE: src/sst_cell.sv
// One slot of the sorted chain: holds a value and an occupied flag.
// Compares against the broadcast key and shifts to or from its neighbors.
`timescale 1ns / 1ps

module sst_cell import sst_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic                    left_lt,
  input  logic                    left_occ,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic                    right_occ,
  input  logic signed [VAL_W-1:0] right_val,
  output logic                    occ,
  output logic signed [VAL_W-1:0] val,
  output logic                    lt,
  output logic                    eq
);

  logic                    occ_next;
  logic signed [VAL_W-1:0] data;
  logic signed [VAL_W-1:0] data_next;

  // Empty slots read as the filler.
  assign val = occ ? data : FILL_VALUE;
  assign lt  = occ && (data < cmd.key);
  assign eq  = occ && (data == cmd.key);

  always_comb begin
    occ_next  = occ;
    data_next = data;
    if (cmd.shift_up && !lt) begin
      // first slot not below the key takes it; the rest take the left value
      data_next = left_lt ? cmd.key : left_val;
      occ_next  = left_occ;
    end else if (cmd.shift_down && !lt) begin
      data_next = right_val;
      occ_next  = right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

FILE: src/sorted_set_table.sv
// Top level of the sorted set table: handshakes, count, status and cell chain.
// Depends on sst_pkg, sst_cell and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, opcode,value | request
//  out     | out_valid, out_stall, status,    | result
//          | element_count                    |
//  cfg     | cfg_valid, cfg_ready, cfg_data   | capacity write
//
// One transaction per cycle unless stalled: every cell compares its slot with
// the key and shifts in the same cycle, the result lands in the output
// register next edge. in_stall is high only while a held result is stalled at
// the output. Reset clears the count and every occupied flag; no clearing pass.
// The capacity register resets to 64 and cfg_ready is always high.

module sorted_set_table import sst_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  opcode,
  input  logic signed [VAL_W-1:0]     value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [CNT_OUT_W-1:0]        element_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CAP_W-1:0]            cfg_data
);

  `include "assert_macros.svh"

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity_limit;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic             accept;
  cmd_t             cmd;
  logic             present;
  logic             full;
  logic             is_fill;
  status_t          status_next;

  logic [DEPTH-1:0]              occ_vec;
  logic [DEPTH-1:0]              lt_vec;
  logic [DEPTH-1:0]              eq_vec;
  logic signed [VAL_W-1:0]       val_vec [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign present = |eq_vec;
  assign is_fill = (value == FILL_VALUE);
  assign full    = (CMPW'(count) >= CMPW'(capacity_limit)) || (count >= CW'(DEPTH));

  always_comb begin
    cmd.key        = value;
    cmd.shift_up   = 1'b0;
    cmd.shift_down = 1'b0;
    status_next    = ST_ABSENT;
    count_next     = count;
    if (!is_fill) begin
      case (opcode_t'(opcode))
        OP_INSERT: begin
          if (present) begin
            status_next = ST_DUP;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            status_next  = ST_DONE;
            cmd.shift_up = accept;
          end
        end
        OP_REMOVE: begin
          if (present) begin
            status_next    = ST_DONE;
            cmd.shift_down = accept;
          end
        end
        default: begin
          // lookup; the spare opcode acts the same
          status_next = present ? ST_DONE : ST_ABSENT;
        end
      endcase
    end
    if (cmd.shift_up) begin
      count_next = count + CW'(1);
    end else if (cmd.shift_down) begin
      count_next = count - CW'(1);
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                    l_lt;
      logic                    l_occ;
      logic signed [VAL_W-1:0] l_val;
      logic                    r_occ;
      logic signed [VAL_W-1:0] r_val;

      if (i == 0) begin : g_first
        assign l_lt  = 1'b1;
        assign l_occ = 1'b1;
        assign l_val = FILL_VALUE;
      end else begin : g_mid_l
        assign l_lt  = lt_vec[i-1];
        assign l_occ = occ_vec[i-1];
        assign l_val = val_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign r_occ = 1'b0;
        assign r_val = FILL_VALUE;
      end else begin : g_mid_r
        assign r_occ = occ_vec[i+1];
        assign r_val = val_vec[i+1];
      end

      sst_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cmd       (cmd),
        .left_lt   (l_lt),
        .left_occ  (l_occ),
        .left_val  (l_val),
        .right_occ (r_occ),
        .right_val (r_val),
        .occ       (occ_vec[i]),
        .val       (val_vec[i]),
        .lt        (lt_vec[i]),
        .eq        (eq_vec[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      capacity_limit <= CAP_RESET;
      out_valid      <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      element_count <= CNT_OUT_W'(count_next);
    end
  end

  `SST_ASSERT(a_count_bound, count <= CW'(DEPTH))
  `SST_ASSERT(a_occ_matches_count, $countones(occ_vec) == 32'(count))
  `SST_ASSERT(a_occ_prefix, (occ_vec & (occ_vec + DEPTH'(1))) == '0)
  `SST_ASSERT_NEXT(a_insert_grows, cmd.shift_up, count == $past(count) + CW'(1))
  `SST_ASSERT_NEXT(a_stall_holds, in_stall, out_valid && $stable(status))

endmodule

FILE: tb/sorted_set_checker.sv
`timescale 1ns / 1ps
// Scoreboard for sorted_set_table: keeps its own sorted table, updated on every
// accepted request, and checks each accepted result in order. Depends on sst_pkg.

module sorted_set_checker import sst_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              opcode,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [1:0]              status,
  input  logic [CNT_OUT_W-1:0]    element_count,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data,
  output int                      mismatches,
  output int                      outstanding
);

  typedef struct packed {
    status_t                st;
    logic [CNT_OUT_W-1:0]   cnt;
  } set_result_t;

  logic signed [VAL_W-1:0] held_vals [DEPTH_DEF];
  int                      held_count;
  logic [CAP_W-1:0]        capacity;
  set_result_t             results_due [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies one operation to the model table and returns its status.
  task automatic run_set_op(input logic [1:0] op, input logic signed [VAL_W-1:0] v,
                            output status_t st);
    int pos;
    int lim;
    int j;
    bit present;
    pos = 0;
    lim = (capacity > DEPTH_DEF) ? DEPTH_DEF : int'(capacity);
    if (v == FILL_VALUE) begin
      st = ST_ABSENT;
      return;
    end
    while (pos < held_count && held_vals[pos] < v) pos++;
    present = (pos < held_count) && (held_vals[pos] == v);
    if (op == OP_INSERT) begin
      if (present) begin
        st = ST_DUP;
      end else if (held_count >= lim) begin
        st = ST_FULL;
      end else begin
        for (j = held_count; j > pos; j--) held_vals[j] = held_vals[j-1];
        held_vals[pos] = v;
        held_count++;
        st = ST_DONE;
      end
    end else if (op == OP_REMOVE) begin
      if (!present) begin
        st = ST_ABSENT;
      end else begin
        for (j = pos; j + 1 < held_count; j++) held_vals[j] = held_vals[j+1];
        held_vals[held_count-1] = FILL_VALUE;
        held_count--;
        st = ST_DONE;
      end
    end else begin
      // spare opcode behaves as a lookup
      st = present ? ST_DONE : ST_ABSENT;
    end
  endtask

  always @(posedge clk) begin : watch
    status_t     st;
    set_result_t due;
    if (rst) begin
      foreach (held_vals[i]) held_vals[i] = FILL_VALUE;
      held_count = 0;
      capacity = CAP_RESET;
      results_due.delete();
    end else begin
      // results leave no earlier than the cycle after their request, so check first
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          due = results_due.pop_front();
          if (status !== due.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, due.st));
          if (element_count !== due.cnt)
            report_mismatch($sformatf("element_count %0d, expected %0d",
                                      element_count, due.cnt));
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (in_valid && !in_stall) begin
        run_set_op(opcode, value, st);
        due.st = st;
        due.cnt = held_count[CNT_OUT_W-1:0];
        results_due.push_back(due);
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: tb/tb_sorted_set_table.sv
`timescale 1ns / 1ps
// Testbench top for sorted_set_table: clock, reset, request and capacity stimulus,
// random output stalls and the verdict. Depends on sst_pkg and sorted_set_checker.

module tb_sorted_set_table;
  import sst_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 219;
  localparam int POOL_SIZE   = 96;
  localparam int SQUEEZE_LEN = 150;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [1:0]              opcode;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              status;
  logic [CNT_OUT_W-1:0]    element_count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data;

  int  mismatches;
  int  outstanding;
  bit  calm;
  bit  squeeze_req;
  int  squeeze_cycles;

  logic signed [VAL_W-1:0] key_pool [POOL_SIZE];

  sorted_set_table u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_count (element_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  sorted_set_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .element_count (element_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, none while calm, plus one long hold-off once requested.
  initial begin
    out_stall = 1'b0;
    squeeze_cycles = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req && squeeze_cycles < SQUEEZE_LEN) begin
        out_stall <= 1'b1;
        squeeze_cycles++;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  task automatic send_op(input opcode_t op, input logic signed [VAL_W-1:0] v);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering requests and wait for every result to come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void pick_op(input bit filling, output opcode_t op,
                                  output logic signed [VAL_W-1:0] v);
    int r;
    r = $urandom_range(99);
    if (filling)
      op = (r < 60) ? OP_INSERT : (r < 78) ? OP_REMOVE : (r < 95) ? OP_LOOKUP : OP_SPARE;
    else
      op = (r < 20) ? OP_INSERT : (r < 65) ? OP_REMOVE : (r < 95) ? OP_LOOKUP : OP_SPARE;
    r = $urandom_range(99);
    if (r < 3)       v = FILL_VALUE;
    else if (r < 13) v = $urandom();
    else             v = key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  function automatic logic [CAP_W-1:0] phase_capacity(input int ph);
    case (ph)
      0:       return 7'd127;
      1:       return 7'd1;
      2:       return 7'd0;
      3:       return 7'd64;
      4:       return 7'd33;
      5:       return 7'd65;
      6:       return 7'd2;
      default: return 7'd100;
    endcase
  endfunction

  initial begin
    opcode_t                 op;
    logic signed [VAL_W-1:0] v;
    int                      ph;
    int                      k;
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_INSERT;
    value       = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    calm        = 1'b0;
    squeeze_req = 1'b0;

    key_pool[0] = 32'sd2147483647;
    key_pool[1] = -32'sd2147483647;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    key_pool[4] = 32'sd1;
    for (k = 5; k < POOL_SIZE; k++) begin
      key_pool[k] = $urandom();
      if (key_pool[k] == FILL_VALUE) key_pool[k] = 32'sd12345;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes, duplicates, filler, spare opcode
    send_op(OP_LOOKUP, 32'sd0);
    send_op(OP_REMOVE, 32'sd5);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_INSERT, 32'sd2147483647);
    send_op(OP_INSERT, -32'sd2147483647);
    send_op(OP_INSERT, -32'sd1);
    send_op(OP_INSERT, 32'sd1);
    send_op(OP_INSERT, 32'sd0);
    send_op(OP_LOOKUP, -32'sd2147483647);
    send_op(OP_SPARE,  32'sd2147483647);
    send_op(OP_SPARE,  32'sd7);
    send_op(OP_INSERT, FILL_VALUE);
    send_op(OP_LOOKUP, FILL_VALUE);
    send_op(OP_REMOVE, FILL_VALUE);
    send_op(OP_REMOVE, -32'sd2147483647);
    send_op(OP_REMOVE, 32'sd2147483647);
    send_op(OP_REMOVE, 32'sd1);
    send_op(OP_REMOVE, 32'sd1);
    // two left: a full table still reports duplicates first
    write_capacity(7'd2);
    send_op(OP_INSERT, 32'sd5);
    send_op(OP_INSERT, 32'sd0);
    write_capacity(7'd0);
    send_op(OP_INSERT, 32'sd3);
    // capacity below count: full until the count drops under it
    write_capacity(7'd1);
    send_op(OP_INSERT, 32'sd4);
    send_op(OP_REMOVE, -32'sd1);
    send_op(OP_INSERT, 32'sd4);
    send_op(OP_REMOVE, 32'sd0);
    send_op(OP_INSERT, 32'sd4);

    // random: each phase fills the table, then mostly drains it
    for (ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_capacity(ph));
      calm = (ph == 3);
      if (ph == 1) squeeze_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick_op(k < (PHASE_ITEMS * 6) / 10, op, v);
        send_op(op, v);
      end
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/sst_pkg.sv
src/sst_cell.sv
src/sorted_set_table.sv
tb/sorted_set_checker.sv
tb/tb_sorted_set_table.sv
